>>> rtl/assert_macros.svh
// Assertion macros shared by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge, off while reset is low.
`define ASSERT_PROP(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed: %m");

// A signal holds its value in the cycle after the condition.
`define ASSERT_HOLD(name, clk, rst_n, cond, sig) \
	`ASSERT_PROP(name, clk, rst_n, (cond) |=> $stable(sig))

`endif

>>> rtl/imrot_pkg.sv
// ----------------------------------------------------------------------------
// Image rotation package
// Widths, register indexes, command codes and parameter defaults of the rotation block.
// ----------------------------------------------------------------------------
package imrot_pkg;

	localparam int DEF_MAX_WIDTH = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_COEF_FRAC_BITS = 14;

	localparam int PIX_W = 8;
	localparam int POS_W = 8;
	localparam int SIZE_W = 9;
	localparam int COEF_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IN_TDATA_W = 2 * POS_W + PIX_W;
	localparam int OUT_TDATA_W = PIX_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COS_COEF = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIN_COEF = 2'd3;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

endpackage

>>> rtl/image_rotate_nearest.sv
// Throughput: one beat per cycle, loads and fetches alike; the six-stage
// pipeline halts as a whole only while a result waits for m_axis_tready.
// Reset: clears the stage valid bits and loads the register defaults
// (256 x 256 frame, no rotation); the frame memory is not cleared.
// ----------------------------------------------------------------------------
// Nearest-neighbor image rotation
// Loads a grey frame into a synchronous memory and returns, for each fetched
// destination pixel, the source pixel found by inverse rotation.
// ----------------------------------------------------------------------------
module image_rotate_nearest #(
	parameter int MAX_WIDTH = imrot_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = imrot_pkg::DEF_MAX_HEIGHT,
	parameter int COEF_FRAC_BITS = imrot_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [imrot_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [imrot_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// pos_x [7:0], pos_y [15:8], pixel_in [23:16]
	input  logic [imrot_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// command [0]
	input  logic                              s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_out [7:0]
	output logic [imrot_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// inside_res [0]
	output logic                              m_axis_tuser
);
	import imrot_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW = $clog2(DEPTH);
	localparam int D_W = SIZE_W + 2;
	localparam int PROD_W = D_W + COEF_W;
	localparam int SUM_W = ((COEF_FRAC_BITS + SIZE_W > PROD_W - 2) ?
		COEF_FRAC_BITS + SIZE_W : PROD_W - 2) + 2;
	localparam int SHIFT = COEF_FRAC_BITS + 1;
	localparam int QW = SUM_W - SHIFT;
	localparam logic signed [SUM_W-1:0] RND = SUM_W'((64'sd1 <<< SHIFT) - 64'sd1);
	localparam logic [SIZE_W-1:0] W_RST = SIZE_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
	localparam logic [SIZE_W-1:0] H_RST = SIZE_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
	localparam logic [COEF_W-1:0] COS_RST = COEF_W'(64'sd1 <<< COEF_FRAC_BITS);

	logic [SIZE_W-1:0] w_q, h_q;
	logic signed [COEF_W-1:0] cos_q, sin_q;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic fetch_s1, fetch_s2, fetch_s3, fetch_s4, fetch_s5;
	logic [POS_W-1:0] x_s1, x_s2, x_s3, x_s4;
	logic [POS_W-1:0] y_s1, y_s2, y_s3, y_s4;
	logic [PIX_W-1:0] pix_s1, pix_s2, pix_s3, pix_s4, pix_s5;
	logic signed [D_W-1:0] dx_s1, dy_s1;
	logic signed [PROD_W-1:0] dxc_s2, dxs_s2, dyc_s2, dys_s2;
	logic signed [SUM_W-1:0] numx_s3, numy_s3;
	logic signed [QW-1:0] qx_s4, qy_s4;
	logic [AW-1:0] addr_s5;
	logic inside_s5, wr_s5, inside_s6;
	logic [PIX_W-1:0] rd_s6;
	logic [PIX_W-1:0] frame_mem [DEPTH];

	logic [POS_W-1:0] in_x, in_y, in_pix;
	logic signed [SUM_W-1:0] basex, basey, adjx, adjy;
	logic inside_f, load_ok;
	logic [AW-1:0] addr_f;

	assign in_x = s_axis_tdata[POS_W-1:0];
	assign in_y = s_axis_tdata[2*POS_W-1:POS_W];
	assign in_pix = s_axis_tdata[2*POS_W+PIX_W-1:2*POS_W];

	assign adv = !vld_s6 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= W_RST;
			h_q <= H_RST;
			cos_q <= COS_RST;
			sin_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					w_q <= (32'(cfg_data[SIZE_W-1:0]) > MAX_WIDTH) ?
						SIZE_W'(MAX_WIDTH) : cfg_data[SIZE_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					h_q <= (32'(cfg_data[SIZE_W-1:0]) > MAX_HEIGHT) ?
						SIZE_W'(MAX_HEIGHT) : cfg_data[SIZE_W-1:0];
				end
				REG_COS_COEF: cos_q <= cfg_data;
				REG_SIN_COEF: sin_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5 && (fetch_s5 == CMD_FETCH);
		end
	end

	always_comb begin
		basex = SUM_W'($signed({1'b0, w_q})) <<< COEF_FRAC_BITS;
		basey = SUM_W'($signed({1'b0, h_q})) <<< COEF_FRAC_BITS;
		adjx = numx_s3 + (numx_s3[SUM_W-1] ? RND : '0);
		adjy = numy_s3 + (numy_s3[SUM_W-1] ? RND : '0);
		inside_f = !qx_s4[QW-1] && (qx_s4 < QW'($signed({1'b0, w_q})))
			&& !qy_s4[QW-1] && (qy_s4 < QW'($signed({1'b0, h_q})));
		load_ok = (32'(x_s4) < MAX_WIDTH) && (32'(y_s4) < MAX_HEIGHT);
		if (fetch_s4 == CMD_FETCH) begin
			addr_f = AW'($unsigned(qy_s4)) * AW'(MAX_WIDTH) + AW'($unsigned(qx_s4));
		end else begin
			addr_f = AW'(y_s4) * AW'(MAX_WIDTH) + AW'(x_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fetch_s1 <= s_axis_tuser;
			x_s1 <= in_x;
			y_s1 <= in_y;
			pix_s1 <= in_pix;
			dx_s1 <= $signed({2'b00, in_x, 1'b0}) - $signed({2'b00, w_q});
			dy_s1 <= $signed({2'b00, in_y, 1'b0}) - $signed({2'b00, h_q});

			fetch_s2 <= fetch_s1;
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			pix_s2 <= pix_s1;
			dxc_s2 <= dx_s1 * cos_q;
			dxs_s2 <= dx_s1 * sin_q;
			dyc_s2 <= dy_s1 * cos_q;
			dys_s2 <= dy_s1 * sin_q;

			fetch_s3 <= fetch_s2;
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			pix_s3 <= pix_s2;
			numx_s3 <= basex + SUM_W'(dys_s2) + SUM_W'(dxc_s2);
			numy_s3 <= basey + SUM_W'(dyc_s2) - SUM_W'(dxs_s2);

			fetch_s4 <= fetch_s3;
			x_s4 <= x_s3;
			y_s4 <= y_s3;
			pix_s4 <= pix_s3;
			qx_s4 <= adjx[SUM_W-1:SHIFT];
			qy_s4 <= adjy[SUM_W-1:SHIFT];

			fetch_s5 <= fetch_s4;
			pix_s5 <= pix_s4;
			addr_s5 <= addr_f;
			inside_s5 <= inside_f;
			wr_s5 <= vld_s4 && (fetch_s4 == CMD_LOAD) && load_ok;

			inside_s6 <= inside_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr_s5 && vld_s5) begin
				frame_mem[addr_s5] <= pix_s5;
			end
			rd_s6 <= frame_mem[addr_s5];
		end
	end

	assign m_axis_tvalid = vld_s6;
	assign m_axis_tdata = inside_s6 ? rd_s6 : '0;
	assign m_axis_tuser = inside_s6;

endmodule

>>> rtl/imrot_checker.sv
// ----------------------------------------------------------------------------
// Image rotation port checker
// Watches the stream ports of the rotation block over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imrot_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [imrot_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                              m_axis_tuser
);
	import imrot_pkg::*;

	`ASSERT_PROP(a_out_valid_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`ASSERT_HOLD(a_out_data_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata)
	`ASSERT_PROP(a_outside_is_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
	`ASSERT_PROP(a_stall_blocks_input, clk, arst_n, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)

endmodule

bind image_rotate_nearest imrot_checker u_imrot_checker (.*);
